[rtl/lvl_pkg.sv]
// Shared types and codes for the two-ram leveller controller.
// No dependencies; imported by lvl_filter, lvl_action and the top level.
`timescale 1ns / 1ps
`default_nettype none

package lvl_pkg;

   // Operating mode codes
   localparam logic [1:0] MODE_READY  = 2'd0;
   localparam logic [1:0] MODE_MANUAL = 2'd1;
   localparam logic [1:0] MODE_AUTO   = 2'd2;
   localparam logic [1:0] MODE_FAULT  = 2'd3;

   // Level state codes
   localparam logic [1:0] LVL_LEVEL = 2'd0;
   localparam logic [1:0] LVL_NEG   = 2'd1;
   localparam logic [1:0] LVL_POS   = 2'd2;

   // Ram position against the target zone
   localparam logic [1:0] ZONE_BELOW  = 2'd0;
   localparam logic [1:0] ZONE_WITHIN = 2'd1;
   localparam logic [1:0] ZONE_ABOVE  = 2'd2;

   // Configuration register indexes
   localparam logic [2:0] REG_FILTER_INTERVAL = 3'd0;
   localparam logic [2:0] REG_ACTION_INTERVAL = 3'd1;
   localparam logic [2:0] REG_LEVEL_THRESHOLD = 3'd2;
   localparam logic [2:0] REG_ZONE_LOWER      = 3'd3;
   localparam logic [2:0] REG_ZONE_UPPER      = 3'd4;
   localparam logic [2:0] REG_RUN_ENABLE      = 3'd5;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int RSP_BITS    = 12;
   localparam int RSP_W       = 16;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [15:0] interval;
      logic [15:0] threshold;
   } lvl_filt_cfg_type;

   typedef struct packed {
      logic [15:0]        interval;
      logic signed [15:0] zone_lower;
      logic signed [15:0] zone_upper;
      logic               run_enable;
   } lvl_act_cfg_type;

   // Filter status after the current tick
   typedef struct packed {
      logic [1:0] level;
      logic       left_seen;
      logic       right_seen;
   } lvl_filt_stat_type;

   // Action status after the current tick
   typedef struct packed {
      logic [3:0] relay;   // 0 left up, 1 left down, 2 right up, 3 right down
      logic       lamp;
      logic [1:0] mode;
      logic       master_left;
   } lvl_act_stat_type;

   // Saturating tick counter step
   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 16'd1;
   endfunction

endpackage

`default_nettype wire

[rtl/lvl_filter.sv]
// Proximity filter: interval timer, saturating persistence counters, level state.
// Depends on lvl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lvl_filter import lvl_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire lvl_filt_cfg_type  cfg,
   input  wire logic              left_prox_n,
   input  wire logic              right_prox_n,
   output lvl_filt_stat_type      stat
);

   logic [15:0] elapsed_ff, elapsed_in;
   logic [15:0] neg_ff, neg_in;
   logic [15:0] pos_ff, pos_in;
   logic [1:0]  level_ff, level_in;
   logic        left_seen_ff, left_seen_in;
   logic        right_seen_ff, right_seen_in;

   logic [15:0] elapsed_inc;
   logic        fire;
   logic        left_act, right_act;

   assign left_act  = ~left_prox_n;
   assign right_act = ~right_prox_n;

   always_comb begin
      elapsed_inc   = sat_inc(elapsed_ff);
      fire          = (elapsed_inc >= cfg.interval);
      elapsed_in    = fire ? 16'd0 : elapsed_inc;
      neg_in        = neg_ff;
      pos_in        = pos_ff;
      level_in      = level_ff;
      left_seen_in  = left_seen_ff;
      right_seen_in = right_seen_ff;
      if (fire) begin
         left_seen_in  = left_act;
         right_seen_in = right_act;
         neg_in = left_act ? sat_inc(neg_ff) : 16'd0;
         pos_in = right_act ? sat_inc(pos_ff) : 16'd0;
         if (left_act && (neg_in > cfg.threshold)) begin
            level_in = LVL_NEG;
         end
         // positive wins when both have persisted
         if (right_act && (pos_in > cfg.threshold)) begin
            level_in = LVL_POS;
         end
         if (!left_act && !right_act) begin
            level_in = LVL_LEVEL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff    <= '0;
         neg_ff        <= '0;
         pos_ff        <= '0;
         level_ff      <= LVL_LEVEL;
         left_seen_ff  <= 1'b0;
         right_seen_ff <= 1'b0;
      end else if (step) begin
         elapsed_ff    <= elapsed_in;
         neg_ff        <= neg_in;
         pos_ff        <= pos_in;
         level_ff      <= level_in;
         left_seen_ff  <= left_seen_in;
         right_seen_ff <= right_seen_in;
      end
   end

   assign stat.level      = level_in;
   assign stat.left_seen  = left_seen_in;
   assign stat.right_seen = right_seen_in;

endmodule

`default_nettype wire

[rtl/lvl_action.sv]
// Ram readings, action timer, mode selection and relay drive.
// Depends on lvl_pkg; takes the level state from lvl_filter.
`timescale 1ns / 1ps
`default_nettype none

module lvl_action import lvl_pkg::*; #(
   parameter int POSITION_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire lvl_act_cfg_type          cfg,
   input  wire logic [1:0]               level,
   input  wire logic                     manual_switch,
   input  wire logic                     left_new,
   input  wire logic [POSITION_BITS-1:0] left_position,
   input  wire logic                     left_fail,
   input  wire logic                     right_new,
   input  wire logic [POSITION_BITS-1:0] right_position,
   input  wire logic                     right_fail,
   output lvl_act_stat_type              stat
);

   localparam int CMP_W = (POSITION_BITS > 16) ? POSITION_BITS : 16;

   logic [15:0]              elapsed_ff, elapsed_in;
   logic [POSITION_BITS-1:0] left_pos_ff, left_pos_in;
   logic [POSITION_BITS-1:0] right_pos_ff, right_pos_in;
   logic                     left_fail_ff, left_fail_in;
   logic                     right_fail_ff, right_fail_in;
   logic [1:0]               mode_ff, mode_in;
   logic                     master_ff, master_in;
   logic [3:0]               relay_ff, relay_in;
   logic                     lamp_ff, lamp_in;

   logic [15:0]        elapsed_inc;
   logic               fire;
   logic [1:0]         zone_l, zone_r;
   logic signed [CMP_W-1:0] lower_x, upper_x, left_x, right_x;

   assign lower_x = CMP_W'(cfg.zone_lower);
   assign upper_x = CMP_W'(cfg.zone_upper);
   assign left_x  = CMP_W'($signed(left_pos_in));
   assign right_x = CMP_W'($signed(right_pos_in));

   // lower bound checked first, also when the zone is inverted
   always_comb begin
      if (left_x < lower_x)       zone_l = ZONE_BELOW;
      else if (left_x > upper_x)  zone_l = ZONE_ABOVE;
      else                        zone_l = ZONE_WITHIN;
      if (right_x < lower_x)      zone_r = ZONE_BELOW;
      else if (right_x > upper_x) zone_r = ZONE_ABOVE;
      else                        zone_r = ZONE_WITHIN;
   end

   always_comb begin
      left_pos_in   = left_new ? left_position : left_pos_ff;
      left_fail_in  = left_new ? left_fail : left_fail_ff;
      right_pos_in  = right_new ? right_position : right_pos_ff;
      right_fail_in = right_new ? right_fail : right_fail_ff;

      mode_in   = mode_ff;
      if ((left_new && left_fail) || (right_new && right_fail)) begin
         mode_in = MODE_FAULT;
      end

      elapsed_inc = sat_inc(elapsed_ff);
      fire        = (elapsed_inc >= cfg.interval);
      elapsed_in  = fire ? 16'd0 : elapsed_inc;

      master_in = master_ff;
      relay_in  = relay_ff;
      lamp_in   = lamp_ff;

      if (fire) begin
         relay_in = 4'b0000;
         if (cfg.run_enable) begin
            if (manual_switch) begin
               mode_in = MODE_MANUAL;
               lamp_in = 1'b0;
            end else if (!left_fail_in && !right_fail_in) begin
               mode_in = MODE_AUTO;
               lamp_in = 1'b1;
            end else begin
               mode_in = MODE_FAULT;
            end
            if (mode_in == MODE_AUTO) begin
               // a low left ram is raised and takes master before the right side is judged
               if (zone_l == ZONE_BELOW) begin
                  master_in   = 1'b1;
                  relay_in[0] = 1'b1;
               end else if (master_in) begin
                  relay_in[1] = (zone_l == ZONE_ABOVE);
               end else begin
                  relay_in[0] = (level == LVL_NEG);
                  relay_in[1] = (level == LVL_POS);
               end
               if (zone_r == ZONE_BELOW) begin
                  master_in   = 1'b0;
                  relay_in[2] = 1'b1;
               end else if (!master_in) begin
                  relay_in[3] = (zone_r == ZONE_ABOVE);
               end else begin
                  relay_in[3] = (level == LVL_NEG);
                  relay_in[2] = (level == LVL_POS);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff    <= '0;
         left_pos_ff   <= '0;
         right_pos_ff  <= '0;
         left_fail_ff  <= 1'b0;
         right_fail_ff <= 1'b0;
         mode_ff       <= MODE_READY;
         master_ff     <= 1'b1;
         relay_ff      <= '0;
         lamp_ff       <= 1'b0;
      end else if (step) begin
         elapsed_ff    <= elapsed_in;
         left_pos_ff   <= left_pos_in;
         right_pos_ff  <= right_pos_in;
         left_fail_ff  <= left_fail_in;
         right_fail_ff <= right_fail_in;
         mode_ff       <= mode_in;
         master_ff     <= master_in;
         relay_ff      <= relay_in;
         lamp_ff       <= lamp_in;
      end
   end

   assign stat.relay       = relay_in;
   assign stat.lamp        = lamp_in;
   assign stat.mode        = mode_in;
   assign stat.master_left = master_in;

endmodule

`default_nettype wire

[rtl/two_ram_leveller_controller.sv]
// Two-ram leveller controller top level: stream ports, register file, input and result words.
// Depends on lvl_pkg, lvl_filter and lvl_action.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tick word (proximity, switch, ram readings)
//   rsp      out        rsp_tvalid/rsp_tready  relay, lamp, mode and level word
//   csr      in         csr_valid/csr_ready    register index and 16-bit data
//
// One word per clock sustained while rsp_tready stays high; a tick waits in the input register and
// its result is registered into the result register as the tick leaves the input register.
// The input register advances whenever the result register is empty or being taken,
// so a stalled rsp holds both stages and drops req_tready only once both are full.
// Reset is synchronous; all timers, counters and flags return to their power-up values.
// csr_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module two_ram_leveller_controller import lvl_pkg::*; #(
   parameter int POSITION_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output      logic                     req_tready,
   // left_prox_n, right_prox_n, manual_switch, left_new, left_position,
   // left_fail, right_new, right_position, right_fail, zero fill
   input  wire logic [((7 + 2 * POSITION_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output      logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   // left_up, left_down, right_up, right_down, auto_led, mode[1:0],
   // level_state[1:0], master_left, left_prox_seen, right_prox_seen, zero fill
   output      logic [RSP_W-1:0]         rsp_tdata,
   input  wire logic                     csr_valid,
   output      logic                     csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_data
);

   localparam int REQ_BITS = 7 + 2 * POSITION_BITS;
   localparam int LPOS_LSB = 4;
   localparam int LFAIL    = 4 + POSITION_BITS;
   localparam int RNEW     = 5 + POSITION_BITS;
   localparam int RPOS_LSB = 6 + POSITION_BITS;
   localparam int RFAIL    = 6 + 2 * POSITION_BITS;

   lvl_filt_cfg_type  filt_cfg_ff;
   lvl_act_cfg_type   act_cfg_ff;
   lvl_filt_stat_type filt_stat;
   lvl_act_stat_type  act_stat;

   logic                req_valid_ff;
   logic [REQ_BITS-1:0] req_data_ff;
   logic                rsp_valid_ff;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                advance;

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_cfg_ff.interval   <= 16'd10;
         filt_cfg_ff.threshold  <= 16'd10;
         act_cfg_ff.interval    <= 16'd250;
         act_cfg_ff.zone_lower  <= -16'sd100;
         act_cfg_ff.zone_upper  <= 16'sd100;
         act_cfg_ff.run_enable  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_FILTER_INTERVAL: filt_cfg_ff.interval  <= csr_data;
            REG_ACTION_INTERVAL: act_cfg_ff.interval   <= csr_data;
            REG_LEVEL_THRESHOLD: filt_cfg_ff.threshold <= csr_data;
            REG_ZONE_LOWER:      act_cfg_ff.zone_lower <= $signed(csr_data);
            REG_ZONE_UPPER:      act_cfg_ff.zone_upper <= $signed(csr_data);
            REG_RUN_ENABLE:      act_cfg_ff.run_enable <= csr_data[0];
            default: ;
         endcase
      end
   end

   // input word register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_data_ff <= req_tdata[REQ_BITS-1:0];
      end
   end

   lvl_filter u_filter (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .cfg          (filt_cfg_ff),
      .left_prox_n  (req_data_ff[0]),
      .right_prox_n (req_data_ff[1]),
      .stat         (filt_stat)
   );

   lvl_action #(
      .POSITION_BITS (POSITION_BITS)
   ) u_action (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .cfg            (act_cfg_ff),
      .level          (filt_stat.level),
      .manual_switch  (req_data_ff[2]),
      .left_new       (req_data_ff[3]),
      .left_position  (req_data_ff[LPOS_LSB +: POSITION_BITS]),
      .left_fail      (req_data_ff[LFAIL]),
      .right_new      (req_data_ff[RNEW]),
      .right_position (req_data_ff[RPOS_LSB +: POSITION_BITS]),
      .right_fail     (req_data_ff[RFAIL]),
      .stat           (act_stat)
   );

   assign rsp_data_in = {{(RSP_W - RSP_BITS){1'b0}},
                         filt_stat.right_seen, filt_stat.left_seen,
                         act_stat.master_left, filt_stat.level,
                         act_stat.mode, act_stat.lamp, act_stat.relay};

   // result word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
